FILE: rtl/rcl_pkg.sv
package rcl_pkg;

    localparam int MAX_RUNS_DEF   = 32;
    localparam int COORD_BITS_DEF = 10;
    localparam int CNT_W          = 6;
    localparam int IDX_OUT_W      = 5;
    localparam logic [CNT_W-1:0] CNT_MAX = 6'd63;

    typedef enum logic [1:0] {
        ACT_RUN   = 2'd0,
        ACT_EOC   = 2'd1,
        ACT_FLUSH = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        TAG_PLAIN    = 3'd0,
        TAG_SEPARATE = 3'd1,
        TAG_BEGIN    = 3'd2,
        TAG_END      = 3'd3,
        TAG_SPLIT    = 3'd4,
        TAG_JOIN     = 3'd5,
        TAG_BOTH     = 3'd6
    } t_tag;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DROP,
        ST_WALK_RD,
        ST_WALK_EV,
        ST_CUR_WR,
        ST_REP_RD,
        ST_REP_EV,
        ST_REP_END
    } t_state;

    typedef struct packed {
        logic load;
        logic walk_rd;
        logic link;
        logic walk_inc;
        logic cur_wr;
        logic drop;
        logic rep_rd;
        logic rep_emit;
        logic col_end;
        logic flush;
    } t_cmd;

    typedef struct packed {
        t_action act;
        logic    cur_full;
        logic    walk_more;
        logic    ev_above;
        logic    ev_below;
        logic    ev_pe_lt;
        logic    ev_pe_eq;
        logic    rep_more;
        logic    slot_free;
    } t_status;

    function automatic t_tag tag_of(input logic [CNT_W-1:0] p, input logic [CNT_W-1:0] s);
        t_tag t;
        if (p == '0 && s == '0)       t = TAG_SEPARATE;
        else if (p == '0 && s == 6'd1) t = TAG_BEGIN;
        else if (p == 6'd1 && s == '0) t = TAG_END;
        else if (p > 6'd1)             t = (s > 6'd1) ? TAG_BOTH : TAG_JOIN;
        else if (s > 6'd1)             t = TAG_SPLIT;
        else                           t = TAG_PLAIN;
        return t;
    endfunction

endpackage

FILE: rtl/rcl_in_if.sv
interface rcl_in_if #(
    parameter int COORD_BITS = rcl_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            action;
    logic [COORD_BITS-1:0] run_start;
    logic [COORD_BITS-1:0] run_end;

    modport source (output valid, action, run_start, run_end, input ready);
    modport sink   (input valid, action, run_start, run_end, output ready);
endinterface

FILE: rtl/rcl_out_if.sv
interface rcl_out_if;
    logic       valid;
    logic       ready;
    logic       report_kind;
    logic [4:0] run_index;
    logic [5:0] link_count;
    logic       has_link;
    logic [4:0] first_link;
    logic [2:0] run_tag;
    logic       run_dropped;
    logic       last_result;

    modport source (output valid, report_kind, run_index, link_count, has_link, first_link,
                    run_tag, run_dropped, last_result, input ready);
    modport sink   (input valid, report_kind, run_index, link_count, has_link, first_link,
                    run_tag, run_dropped, last_result, output ready);
endinterface

FILE: rtl/rcl_ctrl.sv
module rcl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rcl_pkg::t_status i_status,
    output rcl_pkg::t_cmd    o_cmd
);
    import rcl_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_DROP: begin
                if (i_status.slot_free) begin
                    o_cmd.drop = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_WALK_RD: begin
                if (i_status.walk_more) begin
                    o_cmd.walk_rd = 1'b1;
                    n_state = ST_WALK_EV;
                end else begin
                    n_state = ST_CUR_WR;
                end
            end
            ST_WALK_EV: begin
                if (i_status.ev_above) begin
                    n_state = ST_CUR_WR;
                end else if (i_status.ev_below) begin
                    o_cmd.walk_inc = 1'b1;
                    n_state = ST_WALK_RD;
                end else begin
                    o_cmd.link = 1'b1;
                    if (i_status.ev_pe_lt) begin
                        o_cmd.walk_inc = 1'b1;
                        n_state = ST_WALK_RD;
                    end else begin
                        o_cmd.walk_inc = i_status.ev_pe_eq;
                        n_state = ST_CUR_WR;
                    end
                end
            end
            ST_CUR_WR: begin
                if (i_status.slot_free) begin
                    o_cmd.cur_wr = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_REP_RD: begin
                if (i_status.rep_more) begin
                    o_cmd.rep_rd = 1'b1;
                    n_state = ST_REP_EV;
                end else begin
                    n_state = ST_REP_END;
                end
            end
            ST_REP_EV: begin
                if (i_status.slot_free) begin
                    o_cmd.rep_emit = 1'b1;
                    n_state = ST_REP_RD;
                end
            end
            ST_REP_END: begin
                if (i_status.act == ACT_EOC) o_cmd.col_end = 1'b1;
                else                         o_cmd.flush = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        // dispatch on the action of the beat taken this cycle
        if (r_state == ST_IDLE && i_in_valid) begin
            unique case (i_status.act) inside
                ACT_RUN:             n_state = i_status.cur_full ? ST_DROP : ST_WALK_RD;
                ACT_EOC, ACT_FLUSH:  n_state = ST_REP_RD;
                default:             n_state = ST_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/rcl_dp.sv
module rcl_dp #(
    parameter int MAX_RUNS   = rcl_pkg::MAX_RUNS_DEF,
    parameter int COORD_BITS = rcl_pkg::COORD_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_action,
    input  logic [COORD_BITS-1:0] i_run_start,
    input  logic [COORD_BITS-1:0] i_run_end,
    input  rcl_pkg::t_cmd    i_cmd,
    output rcl_pkg::t_status o_status,
    rcl_out_if.source        o_out
);
    import rcl_pkg::*;

    localparam int IDX_W = $clog2(MAX_RUNS);
    localparam int CW    = $clog2(MAX_RUNS + 1);
    localparam int AW    = IDX_W + 1;
    localparam int DEPTH = 1 << AW;
    // entry layout: start, end, pred, succ, first succ
    localparam int F_LO  = 0;
    localparam int S_LO  = IDX_W;
    localparam int P_LO  = IDX_W + CNT_W;
    localparam int E_LO  = IDX_W + 2 * CNT_W;
    localparam int B_LO  = E_LO + COORD_BITS;
    localparam int ENT_W = B_LO + COORD_BITS;

    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] r_rdata;

    t_action               r_act;
    logic [COORD_BITS-1:0] r_cs, r_ce;
    logic [CNT_W-1:0]      r_preds;
    logic [IDX_W-1:0]      r_first_pred;
    logic [CW-1:0]         r_walk, r_rep, r_prev_cnt, r_cur_cnt;
    logic                  r_bank;

    logic [COORD_BITS-1:0] rd_start, rd_end;
    logic [CNT_W-1:0]      rd_pred, rd_succ, n_succ;
    logic [IDX_W-1:0]      rd_first, n_first, walk_idx, rep_idx, cur_idx;
    logic [COORD_BITS:0]   ce_p1, pe_p1;
    logic                  wr_en, rd_en;
    logic [AW-1:0]         wr_addr, rd_addr;
    logic [ENT_W-1:0]      wr_data;

    assign rd_start = r_rdata[B_LO +: COORD_BITS];
    assign rd_end   = r_rdata[E_LO +: COORD_BITS];
    assign rd_pred  = r_rdata[P_LO +: CNT_W];
    assign rd_succ  = r_rdata[S_LO +: CNT_W];
    assign rd_first = r_rdata[F_LO +: IDX_W];
    assign walk_idx = r_walk[IDX_W-1:0];
    assign rep_idx  = r_rep[IDX_W-1:0];
    assign cur_idx  = r_cur_cnt[IDX_W-1:0];
    assign ce_p1    = {1'b0, r_ce} + 1'b1;
    assign pe_p1    = {1'b0, rd_end} + 1'b1;
    assign n_succ   = (rd_succ < CNT_MAX) ? rd_succ + 1'b1 : rd_succ;
    assign n_first  = (rd_succ == '0) ? cur_idx : rd_first;

    always_comb begin
        o_status.act       = (i_cmd.load) ? t_action'(i_action) : r_act;
        o_status.cur_full  = (r_cur_cnt == CW'(MAX_RUNS));
        o_status.walk_more = (r_walk < r_prev_cnt);
        o_status.ev_above  = ({1'b0, rd_start} > ce_p1);
        o_status.ev_below  = (pe_p1 < {1'b0, r_cs});
        o_status.ev_pe_lt  = (rd_end < r_ce);
        o_status.ev_pe_eq  = (rd_end == r_ce);
        o_status.rep_more  = (r_rep < r_prev_cnt);
        o_status.slot_free = !o_out.valid || o_out.ready;
    end

    always_comb begin
        rd_en   = i_cmd.walk_rd || i_cmd.rep_rd;
        rd_addr = i_cmd.walk_rd ? {r_bank, walk_idx} : {r_bank, rep_idx};
        wr_en   = i_cmd.link || i_cmd.cur_wr;
        if (i_cmd.link) begin
            wr_addr = {r_bank, walk_idx};
            wr_data = {rd_start, rd_end, rd_pred, n_succ, n_first};
        end else begin
            wr_addr = {~r_bank, cur_idx};
            wr_data = {r_cs, r_ce, r_preds, {CNT_W{1'b0}}, {IDX_W{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= t_action'(i_action);
            r_cs  <= i_run_start;
            r_ce  <= i_run_end;
        end
        if (i_cmd.load) begin
            r_preds      <= '0;
            r_first_pred <= '0;
        end else if (i_cmd.link) begin
            if (r_preds == '0)     r_first_pred <= walk_idx;
            if (r_preds < CNT_MAX) r_preds <= r_preds + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk     <= '0;
            r_rep      <= '0;
            r_prev_cnt <= '0;
            r_cur_cnt  <= '0;
            r_bank     <= 1'b0;
        end else begin
            if (i_cmd.load)          r_rep <= '0;
            else if (i_cmd.rep_emit) r_rep <= r_rep + 1'b1;
            if (i_cmd.walk_inc)      r_walk <= r_walk + 1'b1;
            if (i_cmd.cur_wr)        r_cur_cnt <= r_cur_cnt + 1'b1;
            if (i_cmd.col_end) begin
                r_bank     <= ~r_bank;
                r_prev_cnt <= r_cur_cnt;
                r_cur_cnt  <= '0;
                r_walk     <= '0;
            end else if (i_cmd.flush) begin
                r_prev_cnt <= '0;
                r_cur_cnt  <= '0;
                r_walk     <= '0;
            end
        end
    end

    // result register
    logic [IDX_W+IDX_OUT_W-1:0] cur_ext, fp_ext, rep_ext, fs_ext;
    logic [CNT_W-1:0]           n_cnt;
    logic [IDX_OUT_W-1:0]       n_idx, n_fl;

    always_comb begin
        cur_ext = {{IDX_OUT_W{1'b0}}, cur_idx};
        fp_ext  = {{IDX_OUT_W{1'b0}}, r_first_pred};
        rep_ext = {{IDX_OUT_W{1'b0}}, rep_idx};
        fs_ext  = {{IDX_OUT_W{1'b0}}, rd_first};
        if (i_cmd.rep_emit) begin
            n_cnt = rd_succ;
            n_idx = rep_ext[IDX_OUT_W-1:0];
            n_fl  = fs_ext[IDX_OUT_W-1:0];
        end else begin
            n_cnt = r_preds;
            n_idx = cur_ext[IDX_OUT_W-1:0];
            n_fl  = fp_ext[IDX_OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out.valid <= 1'b0;
        end else if (i_cmd.drop || i_cmd.cur_wr || i_cmd.rep_emit) begin
            o_out.valid <= 1'b1;
        end else if (o_out.ready) begin
            o_out.valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.drop) begin
            o_out.report_kind <= 1'b0;
            o_out.run_index   <= '0;
            o_out.link_count  <= '0;
            o_out.has_link    <= 1'b0;
            o_out.first_link  <= '0;
            o_out.run_tag     <= TAG_PLAIN;
            o_out.run_dropped <= 1'b1;
            o_out.last_result <= 1'b1;
        end else if (i_cmd.cur_wr || i_cmd.rep_emit) begin
            o_out.report_kind <= i_cmd.rep_emit;
            o_out.run_index   <= n_idx;
            o_out.link_count  <= n_cnt;
            o_out.has_link    <= (n_cnt != '0);
            o_out.first_link  <= (n_cnt != '0) ? n_fl : '0;
            o_out.run_tag     <= i_cmd.rep_emit ? tag_of(rd_pred, rd_succ) : TAG_PLAIN;
            o_out.run_dropped <= 1'b0;
            o_out.last_result <= i_cmd.rep_emit ? (r_rep + 1'b1 == r_prev_cnt) : 1'b1;
        end
    end

endmodule

FILE: rtl/run_column_linker.sv
// a run beat walks the previous runs in order, reading then comparing each, and its report
//   is registered when the current run is written; a run on a full column is dropped
// input is taken only in idle, so a run holds the input until it is written or dropped;
//   end of column or flush reads and reports each previous run in turn, then ends the
//   column or clears it; output stalls hold the block
// reset: synchronous active low, clears state, counts, bank select and output valid
module run_column_linker #(
    parameter int MAX_RUNS   = rcl_pkg::MAX_RUNS_DEF,
    parameter int COORD_BITS = rcl_pkg::COORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rcl_in_if.sink    i_in,
    rcl_out_if.source o_out
);
    import rcl_pkg::*;

    t_cmd    cmd;
    t_status status;

    rcl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rcl_dp #(
        .MAX_RUNS   (MAX_RUNS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_action    (i_in.action),
        .i_run_start (i_in.run_start),
        .i_run_end   (i_in.run_end),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out       (o_out)
    );

    a_has_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.has_link == (o_out.link_count != 6'd0)))
        else $error("has_link disagrees with link_count");

    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.has_link |-> o_out.first_link == 5'd0)
        else $error("first_link set without link");

    a_cur_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.report_kind |-> o_out.run_tag == TAG_PLAIN && o_out.last_result)
        else $error("bad current run report");

    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.run_dropped |-> !o_out.report_kind && o_out.link_count == 6'd0)
        else $error("dropped report carries data");

endmodule

FILE: verif/run_column_linker_checker.sv
`timescale 1ns / 1ps

module run_column_linker_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rcl_in_if     i_in,
    rcl_out_if    i_out,
    output int    o_errors,
    output int    o_pending
);
    import rcl_pkg::*;

    localparam int NRUNS = MAX_RUNS_DEF;

    typedef struct {
        logic       kind;
        logic [4:0] index;
        logic [5:0] count;
        logic       linked;
        logic [4:0] first;
        t_tag       tag;
        logic       dropped;
        logic       last;
    } t_report;

    // shadow columns
    logic [9:0] old_lo [NRUNS];
    logic [9:0] old_hi [NRUNS];
    logic [5:0] old_preds [NRUNS];
    logic [5:0] old_succs [NRUNS];
    logic [5:0] old_first [NRUNS];
    logic [9:0] new_lo [NRUNS];
    logic [9:0] new_hi [NRUNS];
    logic [5:0] new_preds [NRUNS];
    int         old_cnt, new_cnt, walk;

    t_report reports_due[$];
    int      errors;

    assign o_errors  = errors;
    assign o_pending = reports_due.size();

    task automatic push_report(input logic kind, input int idx, input logic [5:0] cnt,
                               input int first, input t_tag tag, input logic drop,
                               input logic last);
        t_report r;
        r.kind    = kind;
        r.index   = idx[4:0];
        r.count   = cnt;
        r.linked  = (cnt != 0);
        r.first   = (cnt != 0) ? first[4:0] : 5'd0;
        r.tag     = tag;
        r.dropped = drop;
        r.last    = last;
        reports_due = {reports_due, r};
    endtask

    task automatic report_old_column();
        logic [5:0] p, s;
        t_tag       t;
        for (int i = 0; i < old_cnt; i++) begin
            p = old_preds[i];
            s = old_succs[i];
            if (p == 0 && s == 0)      t = TAG_SEPARATE;
            else if (p == 0 && s == 1) t = TAG_BEGIN;
            else if (p == 1 && s == 0) t = TAG_END;
            else if (p > 1)            t = (s > 1) ? TAG_BOTH : TAG_JOIN;
            else if (s > 1)            t = TAG_SPLIT;
            else                       t = TAG_PLAIN;
            push_report(1'b1, i, s, old_first[i], t, 1'b0, i == old_cnt - 1);
        end
    endtask

    task automatic link_run(input logic [9:0] lo, input logic [9:0] hi);
        logic [5:0] preds;
        int         first_pred;
        int         w;
        preds = 0;
        first_pred = 0;
        if (new_cnt >= NRUNS) begin
            push_report(1'b0, 0, 6'd0, 0, TAG_PLAIN, 1'b1, 1'b1);
            return;
        end
        while (walk < old_cnt) begin
            w = walk;
            if (32'(old_lo[w]) > 32'(hi) + 1) break;
            if (32'(old_hi[w]) + 1 < 32'(lo)) begin
                walk++;
                continue;
            end
            if (old_succs[w] == 0) old_first[w] = new_cnt[5:0];
            if (preds == 0) first_pred = w;
            if (old_succs[w] < CNT_MAX) old_succs[w]++;
            if (preds < CNT_MAX) preds++;
            if (old_hi[w] < hi) begin
                walk++;
                continue;
            end
            if (old_hi[w] == hi) walk++;
            break;
        end
        new_lo[new_cnt] = lo;
        new_hi[new_cnt] = hi;
        new_preds[new_cnt] = preds;
        push_report(1'b0, new_cnt, preds, first_pred, TAG_PLAIN, 1'b0, 1'b1);
        new_cnt++;
    endtask

    task automatic predict(input t_action act, input logic [9:0] lo, input logic [9:0] hi);
        case (act)
            ACT_RUN: begin
                link_run(lo, hi);
            end
            ACT_EOC: begin
                report_old_column();
                for (int i = 0; i < new_cnt; i++) begin
                    old_lo[i] = new_lo[i];
                    old_hi[i] = new_hi[i];
                    old_preds[i] = new_preds[i];
                    old_succs[i] = 0;
                    old_first[i] = 0;
                end
                old_cnt = new_cnt;
                new_cnt = 0;
                walk = 0;
            end
            ACT_FLUSH: begin
                report_old_column();
                old_cnt = 0;
                new_cnt = 0;
                walk = 0;
            end
            default: ;
        endcase
    endtask

    task automatic compare_report();
        t_report e;
        if (reports_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected report beat kind=%0d idx=%0d", $time,
                     i_out.report_kind, i_out.run_index);
            return;
        end
        e = reports_due.pop_front();
        if (i_out.report_kind !== e.kind) begin
            errors++;
            $display("%0t: report_kind exp %0d got %0d", $time, e.kind, i_out.report_kind);
        end
        if (i_out.run_index !== e.index) begin
            errors++;
            $display("%0t: run_index exp %0d got %0d", $time, e.index, i_out.run_index);
        end
        if (i_out.link_count !== e.count) begin
            errors++;
            $display("%0t: link_count exp %0d got %0d", $time, e.count, i_out.link_count);
        end
        if (i_out.has_link !== e.linked) begin
            errors++;
            $display("%0t: has_link exp %0d got %0d", $time, e.linked, i_out.has_link);
        end
        if (i_out.first_link !== e.first) begin
            errors++;
            $display("%0t: first_link exp %0d got %0d", $time, e.first, i_out.first_link);
        end
        if (i_out.run_tag !== e.tag) begin
            errors++;
            $display("%0t: run_tag exp %0d got %0d", $time, e.tag, i_out.run_tag);
        end
        if (i_out.run_dropped !== e.dropped) begin
            errors++;
            $display("%0t: run_dropped exp %0d got %0d", $time, e.dropped,
                     i_out.run_dropped);
        end
        if (i_out.last_result !== e.last) begin
            errors++;
            $display("%0t: last_result exp %0d got %0d", $time, e.last,
                     i_out.last_result);
        end
    endtask

    initial begin
        errors  = 0;
        old_cnt = 0;
        new_cnt = 0;
        walk    = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            old_cnt = 0;
            new_cnt = 0;
            walk    = 0;
            reports_due.delete();
        end else begin
            if (i_in.valid && i_in.ready)
                predict(t_action'(i_in.action), i_in.run_start, i_in.run_end);
            if (i_out.valid && i_out.ready)
                compare_report();
        end
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rcl_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    bit   calm;
    int   items_sent;

    rcl_in_if  in_ch ();
    rcl_out_if out_ch ();

    run_column_linker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    run_column_linker_checker checker_inst (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send(input t_action act, input logic [9:0] lo, input logic [9:0] hi);
        int gap;
        in_ch.valid     <= 1'b1;
        in_ch.action    <= act;
        in_ch.run_start <= lo;
        in_ch.run_end   <= hi;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
        gap = idle_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // sorted column of runs, random gaps of 0..3 rows between them
    task automatic send_column(input int nruns, input int first_row);
        int pos, len;
        pos = first_row;
        for (int i = 0; i < nruns && pos <= 1023; i++) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 6);
            if (pos + len > 1023) len = 1023 - pos;
            send(ACT_RUN, pos[9:0], 10'(pos + len));
            pos = pos + len + 1 + $urandom_range(0, 3);
        end
        send(ACT_EOC, 10'd0, 10'd0);
    endtask

    // receiver: random stalls, one long hold-off so the block backs up
    initial begin
        int cycle;
        int stall;
        cycle = 0;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            cycle++;
            if (cycle == 300) begin
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                cycle += 400;
            end
            stall = idle_len();
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                cycle += stall;
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        int lo, hi, waited;
        items_sent      = 0;
        calm            = 1'b0;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.action    = ACT_NONE;
        in_ch.run_start = '0;
        in_ch.run_end   = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty ends, unused code, extremes, gap tolerance, overflow
        send(ACT_FLUSH, 10'd0, 10'd0);
        send(ACT_EOC, 10'd0, 10'd0);
        send(ACT_NONE, 10'd1023, 10'd1023);
        send(ACT_RUN, 10'd0, 10'd0);
        send(ACT_RUN, 10'd2, 10'd5);
        send(ACT_RUN, 10'd7, 10'd9);
        send(ACT_RUN, 10'd1023, 10'd1023);
        send(ACT_EOC, 10'd0, 10'd0);
        send(ACT_RUN, 10'd0, 10'd9);
        send(ACT_RUN, 10'd11, 10'd11);
        send(ACT_RUN, 10'd1021, 10'd1022);
        send(ACT_EOC, 10'd0, 10'd0);
        send(ACT_RUN, 10'd0, 10'd12);
        send(ACT_RUN, 10'd600, 10'd500);
        send(ACT_EOC, 10'd0, 10'd0);
        send(ACT_FLUSH, 10'd0, 10'd0);
        // fill a column past capacity
        for (int i = 0; i < 34; i++)
            send(ACT_RUN, 10'(i * 30), 10'(i * 30 + 1));
        send(ACT_EOC, 10'd0, 10'd0);
        send_column(34, 0);
        send(ACT_FLUSH, 10'd0, 10'd0);

        while (items_sent < 100) begin
            calm = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 9))
                0: begin
                    lo = $urandom_range(0, 1023);
                    hi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                     : $urandom_range(lo, 1023);
                    send(ACT_RUN, 10'(lo), 10'(hi));
                end
                1: send(t_action'($urandom_range(1, 3)), 10'($urandom), 10'($urandom));
                2: send_column($urandom_range(20, 33), $urandom_range(0, 40));
                default: begin
                    send_column($urandom_range(1, 6), $urandom_range(0, 1023));
                    if ($urandom_range(0, 3) == 0) send(ACT_FLUSH, 10'd0, 10'd0);
                end
            endcase
        end
        send(ACT_EOC, 10'd0, 10'd0);
        send(ACT_FLUSH, 10'd0, 10'd0);
        in_ch.valid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (150) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
